>>> rtl/core/cfs_pkg.sv
package cfs_pkg;

    // sample width is fixed by the item structs
    localparam int SAMPLE_BITS = 16;

    // defaults for the top level parameters
    localparam int DEFAULT_PHASE_BITS = 32;
    localparam int DEFAULT_TABLE_BITS = 10;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RUN_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 1'b1;

    // table magnitude: Q1.30, full scale needs 31 bits
    localparam int SIN_BITS = 31;
    localparam logic [63:0] HALFPI_Q48 = 64'h1921FB54442D2;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_i;
        logic signed [SAMPLE_BITS-1:0] in_q;
    } cfs_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
    } cfs_out_t;

    // unsigned quotient by shift and subtract for the series coefficients
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // one quarter-wave sine entry, sin(pi/2 * k / 2^tbits) in Q1.30,
    // from a Horner series evaluated at elaboration
    function automatic logic [SIN_BITS-1:0] sin_entry(input int unsigned k,
                                                      input int unsigned tbits);
        logic [63:0] rnd;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] d;
        rnd = 64'd1 << (16 + tbits);
        x = (64'(k) * HALFPI_Q48 + rnd) >> (17 + tbits);
        y = (x * x) >> 31;
        t = 64'd1 << 31;
        for (int j = 8; j >= 1; j--) begin
            d = 64'((2 * j) * (2 * j + 1));
            t = (64'd1 << 31) - udiv64((y * t) >> 31, d);
        end
        s = (x * t) >> 31;
        s = (s + 64'd1) >> 1;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        return s[SIN_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/complex_frequency_shifter.sv
// Complex frequency shifter: each I/Q item is multiplied by cos(p) + j*sin(p),
// where p is a phase accumulator (a fraction of a turn, PHASE_BITS wide) that
// advances by phase_step after every item while run_enable is set. Results are
// rounded half up and saturated to the sample width; with run_enable clear the
// item passes through unchanged and the phase holds. Any configuration write
// clears the phase. The block takes one item per clock while the output is not
// stalled; an item passes a registered dual-read sine table of 2^TABLE_BITS + 1
// entries (cosine read from the mirrored address), a stage of four multipliers,
// and a stage that sums, rounds and saturates into the output register. The
// phase accumulator is one add per item, so back-to-back items see consecutive
// phases. Each stage holds its item while the stage after it is full and
// stalled, so input is taken as long as the pipeline has a free slot.
module complex_frequency_shifter
    #(
        parameter int PHASE_BITS = cfs_pkg::DEFAULT_PHASE_BITS,
        parameter int TABLE_BITS = cfs_pkg::DEFAULT_TABLE_BITS
    )
    (
        input  logic                                aclk,
        input  logic                                aresetn,
        input  logic                                cfg_we,
        input  logic [cfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
        input  logic [cfs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
        input  logic                                s_valid,
        output logic                                s_ready,
        input  cfs_pkg::cfs_in_t                    s_data,
        output logic                                m_valid,
        input  logic                                m_ready,
        output cfs_pkg::cfs_out_t                   m_data
    );
    import cfs_pkg::*;

    localparam int TBL_N  = 1 << TABLE_BITS;
    localparam int ADDR_W = TABLE_BITS + 1;
    localparam int TRIG_W = SIN_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - 30;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << 29);
    localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] RND_MIN  = -RND_MAX - RND_W'(1);

    typedef logic [SIN_BITS-1:0] sin_rom_t [TBL_N+1];

    function automatic sin_rom_t build_rom();
        sin_rom_t rom;
        for (int k = 0; k <= TBL_N; k++) begin
            rom[k] = sin_entry(k, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_rom();

    // round half up at bit 30, then saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
            input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] biased;
        logic signed [RND_W-1:0] r;
        biased = v + RND_HALF;
        r = RND_W'(biased >>> 30);
        if (r > RND_MAX) begin
            r = RND_MAX;
        end else if (r < RND_MIN) begin
            r = RND_MIN;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    // configuration and phase state
    logic                           run_enable_reg, run_enable_next;
    logic [CFG_DATA_BITS-1:0]       phase_step_reg, phase_step_next;
    logic [PHASE_BITS-1:0]          phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0]          step_aligned;

    // pipeline
    logic                           st1_valid_reg, st2_valid_reg, m_valid_reg;
    logic                           st1_en, st2_en, st3_en;
    logic                           s_accept;
    cfs_in_t                        st1_data_reg, st2_data_reg;
    logic                           st1_run_reg, st2_run_reg;
    logic [1:0]                     st1_quad_reg;
    logic [SIN_BITS-1:0]            rom_a_reg, rom_b_reg;
    logic [TABLE_BITS-1:0]          tbl_k;
    logic [ADDR_W-1:0]              addr_a, addr_b;
    logic signed [TRIG_W-1:0]       mag_a, mag_b, sin_val, cos_val;
    logic signed [PROD_W-1:0]       prod_ic_reg, prod_qs_reg, prod_is_reg, prod_qc_reg;
    logic signed [SUM_W-1:0]        sum_i, sum_q;
    cfs_out_t                       m_data_reg, m_data_next;

    // stage enables: a stage moves when the next one is empty or moving
    assign st3_en   = !m_valid_reg || m_ready;
    assign st2_en   = !st2_valid_reg || st3_en;
    assign st1_en   = !st1_valid_reg || st2_en;
    assign s_ready  = st1_en;
    assign s_accept = s_valid && s_ready;

    // phase step aligned to the accumulator width
    if (PHASE_BITS >= 32) begin : g_step_wide
        assign step_aligned = PHASE_BITS'(signed'(phase_step_reg)) << (PHASE_BITS - 32);
    end else begin : g_step_narrow
        assign step_aligned = phase_step_reg[31 -: PHASE_BITS];
    end

    // configuration writes and phase advance
    always_comb begin
        run_enable_next = run_enable_reg;
        phase_step_next = phase_step_reg;
        phase_acc_next  = phase_acc_reg;
        priority if (cfg_we) begin
            phase_acc_next = '0;
            unique case (cfg_index)
                CFG_RUN_ENABLE: run_enable_next = cfg_wdata[0];
                CFG_PHASE_STEP: phase_step_next = cfg_wdata;
            endcase
        end else if (s_accept && run_enable_reg) begin
            phase_acc_next = phase_acc_reg + step_aligned;
        end else begin
            phase_acc_next = phase_acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_enable_reg <= 1'b0;
            phase_step_reg <= '0;
            phase_acc_reg  <= '0;
        end else begin
            run_enable_reg <= run_enable_next;
            phase_step_reg <= phase_step_next;
            phase_acc_reg  <= phase_acc_next;
        end
    end

    // table addresses from the top phase bits
    assign tbl_k  = phase_acc_reg[PHASE_BITS-3 -: TABLE_BITS];
    assign addr_a = {1'b0, tbl_k};
    assign addr_b = ADDR_W'(TBL_N) - {1'b0, tbl_k};

    // stage 1: table read and item capture
    always_ff @(posedge aclk) begin
        if (st1_en) begin
            rom_a_reg    <= SIN_ROM[addr_a];
            rom_b_reg    <= SIN_ROM[addr_b];
            st1_data_reg <= s_data;
            st1_run_reg  <= run_enable_reg;
            st1_quad_reg <= phase_acc_reg[PHASE_BITS-1 -: 2];
        end
    end

    // quadrant mapping to signed sine and cosine
    assign mag_a = signed'({1'b0, rom_a_reg});
    assign mag_b = signed'({1'b0, rom_b_reg});

    always_comb begin
        unique case (st1_quad_reg)
            2'd0: begin
                sin_val = mag_a;
                cos_val = mag_b;
            end
            2'd1: begin
                sin_val = mag_b;
                cos_val = -mag_a;
            end
            2'd2: begin
                sin_val = -mag_a;
                cos_val = -mag_b;
            end
            default: begin
                sin_val = -mag_b;
                cos_val = mag_a;
            end
        endcase
    end

    // stage 2: products
    always_ff @(posedge aclk) begin
        if (st2_en) begin
            prod_ic_reg  <= PROD_W'(st1_data_reg.in_i) * PROD_W'(cos_val);
            prod_qs_reg  <= PROD_W'(st1_data_reg.in_q) * PROD_W'(sin_val);
            prod_is_reg  <= PROD_W'(st1_data_reg.in_i) * PROD_W'(sin_val);
            prod_qc_reg  <= PROD_W'(st1_data_reg.in_q) * PROD_W'(cos_val);
            st2_data_reg <= st1_data_reg;
            st2_run_reg  <= st1_run_reg;
        end
    end

    // stage 3: sum, round, saturate or pass through
    assign sum_i = SUM_W'(prod_ic_reg) - SUM_W'(prod_qs_reg);
    assign sum_q = SUM_W'(prod_is_reg) + SUM_W'(prod_qc_reg);

    always_comb begin
        if (st2_run_reg) begin
            m_data_next.out_i = round_sat(sum_i);
            m_data_next.out_q = round_sat(sum_q);
        end else begin
            m_data_next.out_i = st2_data_reg.in_i;
            m_data_next.out_q = st2_data_reg.in_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (st3_en) begin
            m_data_reg <= m_data_next;
        end
    end

    // item valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (st1_en) begin
                st1_valid_reg <= s_valid;
            end
            if (st2_en) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (st3_en) begin
                m_valid_reg <= st2_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a configuration write leaves the phase at zero
    a_cfg_clears_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> phase_acc_reg == '0)
        else $error("phase not cleared after configuration write");

    // input is held off only when every stage is full and the output stalls
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (st1_valid_reg && st2_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with a free pipeline slot");

    // phase moves only on an accepted item or a configuration write
    a_phase_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept && !cfg_we) |=> $stable(phase_acc_reg))
        else $error("phase changed without an item");

    // pass-through items leave the phase alone
    a_phase_holds_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !run_enable_reg && !cfg_we) |=> $stable(phase_acc_reg))
        else $error("phase advanced while not running");

    // a stalled output keeps its item
    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output item changed while stalled");
`endif

endmodule

>>> tb/tb_complex_frequency_shifter.sv
`timescale 1ns / 1ps

module tb_complex_frequency_shifter;

    import cfs_pkg::*;

    localparam int  QUARTER_N   = 1 << DEFAULT_TABLE_BITS;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  HOLD_CYCLES = 300;

    // models the shifter and keeps the results still due from the block
    class mixer_scoreboard;
        longint        sine_tab[0:QUARTER_N];
        logic          run_on;
        logic [31:0]   step_turns;
        logic [31:0]   phase_turns;
        cfs_out_t      shifted_due[$];
        int            mismatch_count;

        function new();
            build_sine();
            run_on = 1'b0;
            step_turns = '0;
            phase_turns = '0;
            mismatch_count = 0;
        endfunction

        // quarter-wave sine in Q1.30 from a Horner series on a Q31 argument
        function void build_sine();
            longint unsigned halfpi_q48;
            longint unsigned arg;
            longint unsigned arg_sq;
            longint unsigned term;
            longint unsigned prod;
            longint unsigned div;
            halfpi_q48 = 64'h1921FB54442D2;
            for (int k = 0; k <= QUARTER_N; k++) begin
                arg = (longint'(k) * halfpi_q48 + (64'd1 << (16 + DEFAULT_TABLE_BITS)))
                      >> (17 + DEFAULT_TABLE_BITS);
                arg_sq = (arg * arg) >> 31;
                term = 64'd1 << 31;
                for (int j = 8; j >= 1; j--) begin
                    div = longint'((2 * j) * (2 * j + 1));
                    term = (64'd1 << 31) - (((arg_sq * term) >> 31) / div);
                end
                prod = (arg * term) >> 31;
                prod = (prod + 64'd1) >> 1;
                if (prod > (64'd1 << 30)) begin
                    prod = 64'd1 << 30;
                end
                sine_tab[k] = longint'(prod);
            end
        endfunction

        // any register write clears the phase
        function void set_config(logic run, logic [31:0] step);
            run_on = run;
            step_turns = step;
            phase_turns = '0;
        endfunction

        // round half up from Q30 and clamp to the sample range
        function logic [SAMPLE_BITS-1:0] round_clamp(longint acc);
            longint r;
            r = (acc + 64'sd536870912) >>> 30;
            if (r > 32767) begin
                r = 32767;
            end
            if (r < -32768) begin
                r = -32768;
            end
            return r[SAMPLE_BITS-1:0];
        endfunction

        function cfs_out_t mix_sample(cfs_in_t item);
            cfs_out_t      res;
            logic [11:0]   top;
            int unsigned   idx;
            longint        vi;
            longint        vq;
            longint        cv;
            longint        sv;
            if (!run_on) begin
                res.out_i = item.in_i;
                res.out_q = item.in_q;
                return res;
            end
            vi = $signed(item.in_i);
            vq = $signed(item.in_q);
            top = phase_turns[31:20];
            idx = top[9:0];
            // quadrant from the top two phase bits
            case (top[11:10])
                2'd0: begin
                    sv = sine_tab[idx];
                    cv = sine_tab[QUARTER_N - idx];
                end
                2'd1: begin
                    sv = sine_tab[QUARTER_N - idx];
                    cv = -sine_tab[idx];
                end
                2'd2: begin
                    sv = -sine_tab[idx];
                    cv = -sine_tab[QUARTER_N - idx];
                end
                default: begin
                    sv = -sine_tab[QUARTER_N - idx];
                    cv = sine_tab[idx];
                end
            endcase
            res.out_i = round_clamp(vi * cv - vq * sv);
            res.out_q = round_clamp(vi * sv + vq * cv);
            phase_turns = phase_turns + step_turns;
            return res;
        endfunction

        function void note_sample(cfs_in_t item);
            shifted_due.push_back(mix_sample(item));
        endfunction

        function void check_shifted(cfs_out_t got);
            cfs_out_t want;
            if (shifted_due.size() == 0) begin
                $error("unexpected item: out_i %0d out_q %0d",
                       $signed(got.out_i), $signed(got.out_q));
                mismatch_count++;
                return;
            end
            want = shifted_due.pop_front();
            if (got.out_i !== want.out_i) begin
                $error("out_i: expected %0d, actual %0d",
                       $signed(want.out_i), $signed(got.out_i));
                mismatch_count++;
            end
            if (got.out_q !== want.out_q) begin
                $error("out_q: expected %0d, actual %0d",
                       $signed(want.out_q), $signed(got.out_q));
                mismatch_count++;
            end
        endfunction

        function int pending();
            return shifted_due.size();
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    cfs_in_t                    s_data;
    logic                       m_valid;
    logic                       m_ready;
    cfs_out_t                   m_data;

    mixer_scoreboard  sb;
    int               src_idle_pct;
    int               sink_stall_pct;
    logic             hold_request;
    int               cycle_count;

    complex_frequency_shifter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_shifted(m_data);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] corner_value();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic cfs_in_t rand_sample();
        cfs_in_t item;
        item.in_i = ($urandom_range(99) < 15) ? corner_value() : 16'($urandom);
        item.in_q = ($urandom_range(99) < 15) ? corner_value() : 16'($urandom);
        return item;
    endfunction

    function automatic cfs_in_t pack_sample(logic [15:0] vi, logic [15:0] vq);
        cfs_in_t item;
        item.in_i = vi;
        item.in_q = vq;
        return item;
    endfunction

    function automatic void set_idling(int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
            default: begin src_idle_pct = 37; sink_stall_pct = 37; end
        endcase
    endfunction

    // called and returns at a falling edge; valid stays up between items unless an idle gap is drawn
    task automatic send_sample(input cfs_in_t item);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_sample(item);
        @(negedge aclk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_config(input logic run, input logic [31:0] step);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RUN_ENABLE;
        cfg_wdata <= {31'd0, run};
        @(negedge aclk);
        cfg_index <= CFG_PHASE_STEP;
        cfg_wdata <= step;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_config(run, step);
        @(negedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int mode,
                             input int hold_at, input int drain_at);
        set_idling(mode);
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at) begin
                hold_request = 1'b1;
            end
            if (i == drain_at) begin
                drain_results();
            end
            send_sample(rand_sample());
        end
        drain_results();
    endtask

    initial begin
        logic [15:0]  sat_pat [0:3];
        logic [31:0]  step_pick;
        sb = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        hold_request = 1'b0;
        cycle_count = 0;
        set_idling(0);
        sat_pat[0] = 16'h7FFF;
        sat_pat[1] = 16'h8000;
        sat_pat[2] = 16'h7FFF;
        sat_pat[3] = 16'h0000;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset state passes samples through
        send_sample(pack_sample(16'h7FFF, 16'h8000));
        send_sample(pack_sample(16'h8000, 16'h7FFF));
        drain_results();

        // explicit pass-through
        write_config(1'b0, 32'h0);
        send_sample(pack_sample(16'h0000, 16'h0000));
        send_sample(pack_sample(16'hFFFF, 16'h0001));
        send_sample(pack_sample(16'h5555, 16'hAAAA));
        drain_results();

        // eighth-turn steps walk all quadrants; full-scale inputs saturate at 45 degrees
        write_config(1'b1, 32'h2000_0000);
        set_idling(3);
        for (int i = 0; i < 12; i++) begin
            send_sample(pack_sample(sat_pat[i % 4], sat_pat[(i + 1) % 4]));
        end
        drain_results();

        // half-turn step, most negative step value
        write_config(1'b1, 32'h8000_0000);
        set_idling(0);
        for (int i = 0; i < 4; i++) begin
            send_sample(pack_sample(16'h7FFF, 16'h8000));
        end
        drain_results();

        // random phases over several settings and idling patterns
        for (int p = 0; p < 8; p++) begin
            case (p)
                1: step_pick = 32'h7FFF_FFFF;
                2: step_pick = 32'h8000_0000;
                4: step_pick = 32'($signed($urandom_range(8191)) - 4096);
                6: step_pick = 32'h0000_0001;
                default: step_pick = $urandom;
            endcase
            write_config(p != 3, step_pick);
            run_phase(150, p % 4, (p == 5) ? 40 : -1, (p == 6) ? 75 : -1);
        end

        // let any stray result show up
        repeat (10) @(negedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected items never arrived", sb.pending());
            sb.mismatch_count++;
        end

        if (sb.mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> complex_frequency_shifter.f
rtl/core/cfs_pkg.sv
rtl/core/complex_frequency_shifter.sv
tb/tb_complex_frequency_shifter.sv
